/* src/chained_hash_set_core_defines.svh */
// Assertion macros for the chained hash set core
`ifndef CHAINED_HASH_SET_CORE_DEFINES_SVH
`define CHAINED_HASH_SET_CORE_DEFINES_SVH
// implication checked every clock, quiet during reset
`define CHS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// implication whose consequent is checked on the next clock
`define CHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

/* src/chs_pkg.sv */
// ----------------------------------------------------------------------------
// chs_pkg
// Shared types and constants of the chained hash set core.
// ----------------------------------------------------------------------------
`default_nettype none
package chs_pkg;
  localparam int unsigned MaxBuckets = 1024;
  localparam int unsigned PoolNodes  = 1024;
  localparam int unsigned BktW  = $clog2(MaxBuckets);
  localparam int unsigned NodeW = $clog2(PoolNodes);
  localparam int unsigned LinkW = NodeW + 1;
  localparam int unsigned KeyW  = 31;
  localparam int unsigned CfgW  = 11;
  localparam logic [LinkW-1:0] NilNode = LinkW'(PoolNodes);

  localparam logic [1:0] FuncInsert = 2'd0;
  localparam logic [1:0] FuncSearch = 2'd1;
  localparam logic [1:0] FuncRemove = 2'd2;

  localparam logic [1:0] StDone     = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StFull     = 2'd2;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // one entry of the head clear sweep
    logic load;        // capture input beat, start modulo
    logic mod_step;    // one restoring step of the modulo
    logic rd_head;     // read bucket head
    logic ins_write;   // perform the insert writes
    logic rd_node;     // read key and link of cur
    logic advance;     // prev <= cur, cur <= link
    logic unlink;      // perform the remove writes
    logic set_status;  // latch status
    logic out_load;    // move the finished result into the output register
    logic [1:0] status;
  } chs_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic       clr_last;
    logic       mod_last;
    logic [1:0] func;
    logic       pool_ok;
    logic       cur_valid;
    logic       key_hit;
    logic       steps_left;
  } chs_sts_t;
endpackage
`default_nettype wire

/* src/chained_hash_set_core.sv */
// ----------------------------------------------------------------------------
// chained_hash_set_core
// Hash set of page numbers with separate chaining over a bounded node pool.
// ----------------------------------------------------------------------------
// channel  dir  handshake                tdata / tuser
// s_axis   in   s_axis_tvalid/tready     tdata[1:0] func, [32:2] page_number
// m_axis   out  m_axis_tvalid/tready     tdata[1:0] status, [11:2] bucket_index
// cfg      in   cfg_valid_i/cfg_ready_o  cfg_data_i = bucket_count
//
// One beat at a time. The bucket comes from a 31-step restoring modulo;
// its head is then read, and a search or remove walks the chain one node
// at a time until a hit, the end of the chain or the step bound.
// After reset a sweep clears all 1024 bucket heads and fills the free
// stack; no input beat is taken meanwhile. A finished result sits in the
// output register; the next beat is accepted before it is taken, and its
// own result then waits in the controller until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none
module chained_hash_set_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,   // func[1:0], page_number[32:2]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // status[1:0], bucket_index[11:2]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [chs_pkg::CfgW-1:0] cfg_data_i
);
  chs_pkg::chs_cmd_t cmd;
  chs_pkg::chs_sts_t sts;
  logic [chs_pkg::CfgW-1:0] bucket_count_q;
  logic [1:0] status;
  logic [chs_pkg::BktW-1:0] bidx;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) bucket_count_q <= chs_pkg::CfgW'(chs_pkg::MaxBuckets);
    else if (cfg_valid_i) bucket_count_q <= cfg_data_i;
  end

  chs_ctrl u_ctrl (
    .clk_i, .rst_ni, .sts_i(sts), .cmd_o(cmd),
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready)
  );

  chs_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts),
    .bucket_count_i(bucket_count_q),
    .func_i(s_axis_tdata[1:0]), .page_number_i(s_axis_tdata[32:2]),
    .status_o(status), .bucket_index_o(bidx)
  );

  assign m_axis_tdata = {4'd0, bidx, status};
endmodule
`default_nettype wire

/* src/chs_datapath.sv */
// ----------------------------------------------------------------------------
// chs_datapath
// Hash modulo unit, chain memories, free stack and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_datapath (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire chs_pkg::chs_cmd_t          cmd_i,
  output chs_pkg::chs_sts_t               sts_o,
  input  wire logic [chs_pkg::CfgW-1:0]   bucket_count_i,
  input  wire logic [1:0]                 func_i,
  input  wire logic [chs_pkg::KeyW-1:0]   page_number_i,
  output logic [1:0]                      status_o,
  output logic [chs_pkg::BktW-1:0]        bucket_index_o
);
  localparam int unsigned KW = chs_pkg::KeyW;
  localparam int unsigned LW = chs_pkg::LinkW;
  localparam int unsigned NW = chs_pkg::NodeW;
  localparam int unsigned BW = chs_pkg::BktW;
  localparam int unsigned CfgW_l = chs_pkg::CfgW;

  logic [LW-1:0] head_mem [chs_pkg::MaxBuckets];
  logic [KW-1:0] key_mem  [chs_pkg::PoolNodes];
  logic [LW-1:0] link_mem [chs_pkg::PoolNodes];
  logic [NW-1:0] free_mem [chs_pkg::PoolNodes];

  logic [1:0]    func_q;
  logic [KW-1:0] key_q;
  logic [KW-1:0] rem_q;     // partial remainder
  logic [KW-1:0] quo_q;     // dividend bits still to shift in
  logic [4:0]    bit_q;
  logic [CfgW_l-1:0] div_q;
  logic [BW-1:0] clr_q;
  logic [LW-1:0] head_q, cur_q, prev_q, link_q;
  logic [KW-1:0] nkey_q;
  logic [LW-1:0] free_total_q;
  logic [NW-1:0] fnode_q;
  logic [LW-1:0] steps_q;
  logic          first_q;
  logic [1:0]    res_status_q;

  // free stack fill during the reset sweep
  logic [NW-1:0] fill_q;
  logic          filling_q;

  // restoring modulo step
  logic [KW:0] shl;
  logic [KW:0] sub;
  assign shl = {rem_q, quo_q[KW-1]};
  assign sub = shl - (KW+1)'(div_q);

  logic [CfgW_l-1:0] div_d;
  always_comb begin
    div_d = bucket_count_i;
    if (div_d == '0) div_d = CfgW_l'(1);
    if (div_d > CfgW_l'(chs_pkg::MaxBuckets)) div_d = CfgW_l'(chs_pkg::MaxBuckets);
  end

  logic [BW-1:0] bkt;
  assign bkt = rem_q[BW-1:0];

  logic [NW-1:0] ins_node;
  assign ins_node = fnode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      free_total_q <= LW'(chs_pkg::PoolNodes);
      func_q       <= '0;
      bit_q        <= '0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + BW'(1);
      if (cmd_i.load) begin
        func_q <= func_i;
        bit_q  <= 5'(KW - 1);
      end else if (cmd_i.mod_step) begin
        bit_q <= bit_q - 5'd1;
      end
      if (cmd_i.ins_write) free_total_q <= free_total_q - LW'(1);
      if (cmd_i.unlink && free_total_q < LW'(chs_pkg::PoolNodes))
        free_total_q <= free_total_q + LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr_step) head_mem[clr_q] <= chs_pkg::NilNode;
    if (filling_q && cmd_i.clr_step) free_mem[fill_q] <= fill_q;
    if (cmd_i.load) begin
      key_q <= page_number_i;
      quo_q <= page_number_i;
      rem_q <= '0;
      div_q <= div_d;
    end else if (cmd_i.mod_step) begin
      quo_q <= {quo_q[KW-2:0], 1'b0};
      rem_q <= sub[KW] ? shl[KW-1:0] : sub[KW-1:0];
    end
    if (cmd_i.rd_head) begin
      head_q  <= head_mem[bkt];
      fnode_q <= free_mem[NW'(free_total_q - LW'(1))];
      first_q <= 1'b1;
      steps_q <= '0;
      prev_q  <= chs_pkg::NilNode;
    end
    if (cmd_i.rd_head) cur_q <= head_mem[bkt];
    if (cmd_i.ins_write) begin
      key_mem[ins_node]  <= key_q;
      link_mem[ins_node] <= head_q;
      head_mem[bkt]      <= LW'(ins_node);
    end
    if (cmd_i.rd_node) begin
      nkey_q <= key_mem[cur_q[NW-1:0]];
      link_q <= link_mem[cur_q[NW-1:0]];
    end
    if (cmd_i.advance) begin
      prev_q  <= cur_q;
      cur_q   <= link_q;
      first_q <= 1'b0;
      steps_q <= steps_q + LW'(1);
    end
    if (cmd_i.unlink) begin
      if (first_q) head_mem[bkt] <= link_q;
      else link_mem[prev_q[NW-1:0]] <= link_q;
      if (free_total_q < LW'(chs_pkg::PoolNodes))
        free_mem[free_total_q[NW-1:0]] <= cur_q[NW-1:0];
    end
    if (cmd_i.set_status) res_status_q <= cmd_i.status;
    // output register only changes once the previous beat has left
    if (cmd_i.out_load) begin
      status_o       <= res_status_q;
      bucket_index_o <= bkt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q    <= '0;
      filling_q <= 1'b1;
    end else if (filling_q && cmd_i.clr_step) begin
      fill_q <= fill_q + NW'(1);
      if (fill_q == NW'(chs_pkg::PoolNodes - 1)) filling_q <= 1'b0;
    end
  end

  always_comb begin
    sts_o.clr_last   = (clr_q == BW'(chs_pkg::MaxBuckets - 1)) &&
                       (!filling_q || fill_q == NW'(chs_pkg::PoolNodes - 1));
    sts_o.mod_last   = (bit_q == 5'd0);
    sts_o.func       = func_q;
    sts_o.pool_ok    = (free_total_q != '0) && (free_total_q <= LW'(chs_pkg::PoolNodes));
    sts_o.cur_valid  = (cur_q < chs_pkg::NilNode);
    sts_o.key_hit    = (nkey_q == key_q);
    sts_o.steps_left = (steps_q < LW'(chs_pkg::PoolNodes));
  end
endmodule
`default_nettype wire

/* src/chs_ctrl.sv */
// ----------------------------------------------------------------------------
// chs_ctrl
// Sequencer: clear sweep, modulo, chain walk, result handshake.
// ----------------------------------------------------------------------------
`default_nettype none
module chs_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire chs_pkg::chs_sts_t sts_i,
  output chs_pkg::chs_cmd_t      cmd_o,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i
);
  localparam logic [3:0] SClear = 4'd0;
  localparam logic [3:0] SIdle  = 4'd1;
  localparam logic [3:0] SMod   = 4'd2;
  localparam logic [3:0] SHead  = 4'd3;
  localparam logic [3:0] SDisp  = 4'd4;
  localparam logic [3:0] SRead  = 4'd5;
  localparam logic [3:0] SCmp   = 4'd6;
  localparam logic [3:0] SOut   = 4'd7;

  logic [3:0] state_q, state_d;
  logic       ov_q, ov_d;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    ov_d        = ov_q;
    in_ready_o  = 1'b0;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    case (state_q)
      SClear: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = SIdle;
      end
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = SMod;
        end
      end
      SMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = SHead;
      end
      SHead: begin
        cmd_o.rd_head = 1'b1;
        state_d = SDisp;
      end
      SDisp: begin
        state_d = SOut;
        cmd_o.set_status = 1'b1;
        cmd_o.status = chs_pkg::StNotFound;
        if (sts_i.func == chs_pkg::FuncInsert) begin
          if (sts_i.pool_ok) begin
            cmd_o.ins_write = 1'b1;
            cmd_o.status = chs_pkg::StDone;
          end else begin
            cmd_o.status = chs_pkg::StFull;
          end
        end else if (sts_i.func == chs_pkg::FuncSearch ||
                     sts_i.func == chs_pkg::FuncRemove) begin
          // walk stops at the end of the chain or after the step bound
          if (sts_i.cur_valid && sts_i.steps_left) begin
            cmd_o.set_status = 1'b0;
            cmd_o.rd_node = 1'b1;
            state_d = SCmp;
          end
        end
      end
      SRead: begin
        cmd_o.rd_node = 1'b1;
        state_d = SCmp;
      end
      SCmp: begin
        if (sts_i.key_hit) begin
          cmd_o.set_status = 1'b1;
          cmd_o.status = chs_pkg::StDone;
          cmd_o.unlink = (sts_i.func == chs_pkg::FuncRemove);
          state_d = SOut;
        end else begin
          cmd_o.advance = 1'b1;
          state_d = SDisp;
        end
      end
      SOut: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          ov_d = 1'b1;
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SClear;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule
`default_nettype wire

/* src/chs_checker.sv */
// ----------------------------------------------------------------------------
// chs_checker
// Port-level checks of the chained hash set core.
// ----------------------------------------------------------------------------
`default_nettype none
`include "chained_hash_set_core_defines.svh"
module chs_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata
);
  `CHS_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `CHS_ASSERT_IMP(a_status, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[1:0] != 2'd3)
  `CHS_ASSERT_NEXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !s_axis_tready)
endmodule
bind chained_hash_set_core chs_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for chained_hash_set_core. A table of directed beats
// is followed by random insert/search/remove traffic under several bucket
// counts, a pass that fills the node pool, and random stalls on both streams.
// Results are checked against a hash set model or a typed row's expectation.
// ----------------------------------------------------------------------------
module testbench;
  localparam logic [1:0] FuncUnknown = 2'd3;
  localparam int unsigned KeyMax = 32'h7FFF_FFFF;

  typedef struct {
    logic [1:0]  func;
    logic [30:0] key;
    bit          typed;     // expectation written into the row
    logic [1:0]  status;
    logic [9:0]  bucket;
  } beat_row_t;

  typedef struct {
    logic [1:0] status;
    logic [9:0] bucket;
  } hash_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [chs_pkg::CfgW-1:0] cfg_data_i = '0;

  chained_hash_set_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Hash set model: bucket heads, node keys/links, free stack
  // --------------------------------------------------------------------------
  logic [chs_pkg::CfgW-1:0]  bucket_cfg;
  logic [chs_pkg::LinkW-1:0] head_of[chs_pkg::MaxBuckets];
  logic [chs_pkg::KeyW-1:0]  key_of[chs_pkg::PoolNodes];
  logic [chs_pkg::LinkW-1:0] link_of[chs_pkg::PoolNodes];
  logic [chs_pkg::NodeW-1:0] free_stack[chs_pkg::PoolNodes];
  int unsigned      free_cnt;

  hash_result_t result_q[$];   // results still owed by the block
  logic [30:0]  known_keys[$]; // keys inserted so far, for hits
  bit           failed = 1'b0;
  bit           calm = 1'b0;   // no idling in the final stretch
  int unsigned  long_hold = 0; // request for a long receiver stall

  function automatic void clear_set();
    bucket_cfg = 11'd1024;
    for (int i = 0; i < chs_pkg::MaxBuckets; i++) head_of[i] = chs_pkg::NilNode;
    for (int i = 0; i < chs_pkg::PoolNodes; i++) free_stack[i] = chs_pkg::NodeW'(i);
    free_cnt = chs_pkg::PoolNodes;
  endfunction

  function automatic hash_result_t hash_set_op(logic [1:0] func, logic [30:0] key);
    hash_result_t r;
    int unsigned div, b, cur, prev, steps;
    logic [chs_pkg::NodeW-1:0] nd;
    div = bucket_cfg;
    if (div == 0) div = 1;
    if (div > chs_pkg::MaxBuckets) div = chs_pkg::MaxBuckets;
    b = key % div;
    r.status = chs_pkg::StNotFound;
    r.bucket = b[9:0];
    if (func == chs_pkg::FuncInsert) begin
      if (free_cnt == 0) begin
        r.status = chs_pkg::StFull;
      end else begin
        free_cnt--;
        nd = free_stack[free_cnt];
        key_of[nd] = key;
        link_of[nd] = head_of[b];
        head_of[b] = chs_pkg::LinkW'(nd);
        r.status = chs_pkg::StDone;
        known_keys.push_back(key);
      end
    end else if (func == chs_pkg::FuncSearch || func == chs_pkg::FuncRemove) begin
      cur = head_of[b];
      prev = chs_pkg::NilNode;
      steps = 0;
      while (cur < chs_pkg::PoolNodes && steps < chs_pkg::PoolNodes) begin
        if (key_of[cur] == key) begin
          r.status = chs_pkg::StDone;
          if (func == chs_pkg::FuncRemove) begin
            if (prev == chs_pkg::NilNode) head_of[b] = link_of[cur];
            else link_of[prev] = link_of[cur];
            link_of[cur] = chs_pkg::NilNode;
            if (free_cnt < chs_pkg::PoolNodes) begin
              free_stack[free_cnt] = chs_pkg::NodeW'(cur);
              free_cnt++;
            end
          end
          break;
        end
        prev = cur;
        cur = link_of[cur];
        steps++;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Input side: optional gap, then hold the beat until it is taken
  // --------------------------------------------------------------------------
  task automatic send_beat(logic [1:0] func, logic [30:0] key, bit typed = 1'b0,
                           hash_result_t want = '{chs_pkg::StDone, 10'd0});
    hash_result_t got;
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 8);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, key, func};
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    got = hash_set_op(func, key);
    result_q.push_back(typed ? want : got);
  endtask

  // drop valid at the acceptance step, then drain all results
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_bucket_count(logic [chs_pkg::CfgW-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    bucket_cfg = value;
  endtask

  function automatic logic [30:0] pick_key();
    if (known_keys.size() != 0 && $urandom_range(0, 9) < 6)
      return known_keys[$urandom_range(0, known_keys.size() - 1)];
    return 31'($urandom() & KeyMax);
  endfunction

  function automatic logic [1:0] pick_func();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return chs_pkg::FuncInsert;
    if (r < 70) return chs_pkg::FuncSearch;
    if (r < 95) return chs_pkg::FuncRemove;
    return FuncUnknown;
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random stall bursts, plus a long hold on request
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left--;
    end else if (long_hold > 0) begin
      m_axis_tready <= 1'b0;
      hold_left = long_hold - 1;
      long_hold = 0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left = $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    hash_result_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("result beat with nothing outstanding: %h", m_axis_tdata);
        failed = 1'b1;
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
          failed = 1'b1;
        end
        if (m_axis_tdata[11:2] !== want.bucket) begin
          $error("bucket_index: expected %0d, got %0d", want.bucket, m_axis_tdata[11:2]);
          failed = 1'b1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed rows: typed expectations hold for the reset bucket count of 1024
  // --------------------------------------------------------------------------
  beat_row_t dir_rows[] = '{
    '{chs_pkg::FuncSearch, 31'd0,         1'b1, chs_pkg::StNotFound, 10'd0},    // empty set
    '{chs_pkg::FuncRemove, 31'd0,         1'b1, chs_pkg::StNotFound, 10'd0},
    '{chs_pkg::FuncInsert, 31'd0,         1'b1, chs_pkg::StDone,     10'd0},
    '{chs_pkg::FuncSearch, 31'd0,         1'b1, chs_pkg::StDone,     10'd0},
    '{chs_pkg::FuncInsert, 31'h7FFF_FFFF, 1'b1, chs_pkg::StDone,     10'd1023}, // top key
    '{chs_pkg::FuncSearch, 31'h7FFF_FFFF, 1'b1, chs_pkg::StDone,     10'd1023},
    '{chs_pkg::FuncRemove, 31'h7FFF_FFFF, 1'b1, chs_pkg::StDone,     10'd1023},
    '{chs_pkg::FuncRemove, 31'h7FFF_FFFF, 1'b1, chs_pkg::StNotFound, 10'd1023}, // absent now
    '{FuncUnknown,         31'd5,         1'b1, chs_pkg::StNotFound, 10'd5},
    '{FuncUnknown,         31'h7FFF_FFFF, 1'b1, chs_pkg::StNotFound, 10'd1023},
    '{chs_pkg::FuncInsert, 31'd5,         1'b1, chs_pkg::StDone,     10'd5},    // duplicates
    '{chs_pkg::FuncInsert, 31'd5,         1'b1, chs_pkg::StDone,     10'd5},
    '{chs_pkg::FuncRemove, 31'd5,         1'b1, chs_pkg::StDone,     10'd5},
    '{chs_pkg::FuncSearch, 31'd5,         1'b1, chs_pkg::StDone,     10'd5},
    '{chs_pkg::FuncRemove, 31'd5,         1'b1, chs_pkg::StDone,     10'd5},
    '{chs_pkg::FuncSearch, 31'd5,         1'b1, chs_pkg::StNotFound, 10'd5},
    '{chs_pkg::FuncInsert, 31'h2AAA_AAAA, 1'b1, chs_pkg::StDone,     10'd682},
    '{chs_pkg::FuncInsert, 31'h5555_5555, 1'b1, chs_pkg::StDone,     10'd341},
    '{chs_pkg::FuncInsert, 31'd1029,      1'b0, chs_pkg::StDone,     10'd0},    // shares bucket 5
    '{chs_pkg::FuncSearch, 31'd5,         1'b0, chs_pkg::StDone,     10'd0},
    '{chs_pkg::FuncRemove, 31'd1029,      1'b0, chs_pkg::StDone,     10'd0},
    '{chs_pkg::FuncSearch, 31'h2AAA_AAAA, 1'b0, chs_pkg::StDone,     10'd0}
  };

  int unsigned phase_cnt[] = '{15, 150, 200, 150, 250};

  initial begin
    logic [chs_pkg::CfgW-1:0] phase_cfg[5];
    clear_set();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_beat(dir_rows[i].func, dir_rows[i].key, dir_rows[i].typed,
                '{dir_rows[i].status, dir_rows[i].bucket});

    // zero count hashes everything to bucket 0
    write_bucket_count(11'd0);
    repeat (20) send_beat(pick_func(), pick_key());

    // above the limit behaves as 1024; fill the pool, then bump into it
    write_bucket_count(11'd2047);
    while (free_cnt > 0) send_beat(chs_pkg::FuncInsert, 31'($urandom() & KeyMax));
    repeat (4) send_beat(chs_pkg::FuncInsert, pick_key());
    repeat (20) send_beat(pick_func(), pick_key());

    // random phases under other counts; chains stay where they were
    phase_cfg = '{11'd1, 11'd7, 11'd1023, 11'd1024, 11'($urandom_range(2, 1022))};
    foreach (phase_cfg[p]) begin
      write_bucket_count(phase_cfg[p]);
      if (p == 4) calm = 1'b1;
      if (p == 2) begin
        // receiver holds off while beats keep coming, so the core backs up
        long_hold = 400;
        repeat (12) send_beat(pick_func(), pick_key());
      end
      repeat (phase_cnt[p]) send_beat(pick_func(), pick_key());
    end

    drain();
    if (!failed) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // worst case: every beat walks a full 1024-node chain under stalls
  initial begin
    #400ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
